/* hw/rtl/cpsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_pkg: shared definitions of the combined generator stream cipher
// Constants, the substitution table, small remainder and rotate helpers,
// the sequencer states and the register indexes.
// ----------------------------------------------------------------------------
package cpsc_pkg;

   localparam logic [31:0] PM_MUL    = 32'd48271;
   localparam logic [31:0] PM_MOD    = 32'd2147483647;
   localparam logic [63:0] XS_MUL    = 64'd2685821657736338717;
   localparam logic [31:0] XS_MUL_LO = XS_MUL[31:0];
   localparam logic [31:0] XS_MUL_HI = XS_MUL[63:32];
   localparam logic [31:0] SEED_LCG  = 32'h85f62713;
   localparam logic [31:0] SEED_LFSR = 32'hc178f733;
   localparam logic [31:0] SEED_NLFS = 32'h49a79a73;
   localparam logic [63:0] SEED_XS   = 64'd17905475062325518273;
   localparam logic [5:0]  SWAP_DIV  = 6'd11;
   localparam logic [5:0]  ROT_DIV   = 6'd29;
   localparam logic [5:0]  ROTBY_DIV = 6'd53;
   localparam logic [2:0]  LAST_ROUND = 3'd6;

   typedef enum logic [0:0] {
      REQ_RESTART = 1'b0,
      REQ_DATA    = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_KEY_LCG  = 2'd0,
      CSR_KEY_LFSR = 2'd1,
      CSR_KEY_NLFS = 2'd2,
      CSR_KEY_XS   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_STEP,
      S_LCG,
      S_M1,
      S_M2,
      S_M3,
      S_M4,
      S_SBOX
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h61, 8'h2d, 8'h19, 8'hf3, 8'he5, 8'hd9, 8'hde, 8'h5f,
      8'h41, 8'h31, 8'ha7, 8'hc2, 8'h48, 8'h02, 8'hef, 8'h98,
      8'h67, 8'hcb, 8'h6e, 8'h4c, 8'hf4, 8'h11, 8'hfa, 8'h87,
      8'h0f, 8'h6f, 8'h0a, 8'h3b, 8'h71, 8'h09, 8'h1a, 8'hb8,
      8'h3c, 8'h44, 8'hd8, 8'hd4, 8'hc8, 8'h91, 8'h6d, 8'h8c,
      8'h2f, 8'hce, 8'h85, 8'h22, 8'hd5, 8'h08, 8'ha6, 8'h97,
      8'h68, 8'hbc, 8'h3a, 8'ha0, 8'hbf, 8'ha5, 8'h47, 8'h94,
      8'h83, 8'hd1, 8'h18, 8'h29, 8'h03, 8'hb2, 8'ha4, 8'hfe,
      8'he4, 8'h4d, 8'hdf, 8'h21, 8'hc0, 8'h70, 8'h4f, 8'h90,
      8'h04, 8'h40, 8'h0b, 8'h49, 8'he0, 8'h25, 8'hd7, 8'hda,
      8'hf8, 8'h1f, 8'h9e, 8'h76, 8'hbb, 8'haa, 8'hc5, 8'h2e,
      8'h72, 8'h64, 8'hd6, 8'h74, 8'h10, 8'h78, 8'hfd, 8'h45,
      8'h80, 8'h4e, 8'h7f, 8'h12, 8'hb7, 8'hc6, 8'hea, 8'hb3,
      8'h37, 8'h5a, 8'hf2, 8'hc3, 8'hb6, 8'h5b, 8'h81, 8'h95,
      8'hbd, 8'hb0, 8'hae, 8'h8f, 8'hd2, 8'hcf, 8'h1e, 8'hc7,
      8'hee, 8'ha1, 8'h7a, 8'hb9, 8'h06, 8'ha8, 8'hb1, 8'h93,
      8'h30, 8'had, 8'h33, 8'h77, 8'h3d, 8'h7c, 8'hb4, 8'h36,
      8'h92, 8'h15, 8'h89, 8'h7e, 8'he9, 8'h17, 8'h07, 8'h8a,
      8'h9f, 8'h32, 8'h2c, 8'hf9, 8'hb5, 8'h7d, 8'heb, 8'h23,
      8'hdc, 8'h2b, 8'h63, 8'h88, 8'h56, 8'h42, 8'h84, 8'h4b,
      8'h0e, 8'hec, 8'h8d, 8'h7b, 8'h05, 8'hed, 8'hca, 8'he8,
      8'he6, 8'hba, 8'h01, 8'h5d, 8'h26, 8'h28, 8'h13, 8'h9d,
      8'h54, 8'h59, 8'hfb, 8'hf0, 8'hd3, 8'hf7, 8'hdb, 8'he7,
      8'hbe, 8'h58, 8'h5e, 8'h99, 8'h65, 8'h8b, 8'h20, 8'ha3,
      8'hc1, 8'h1c, 8'haf, 8'hac, 8'h55, 8'he3, 8'hdd, 8'h62,
      8'h2a, 8'hcc, 8'hd0, 8'he2, 8'h0c, 8'h66, 8'h96, 8'h8e,
      8'hab, 8'hfc, 8'hc4, 8'h1d, 8'h6a, 8'h6c, 8'h3f, 8'h9b,
      8'h9a, 8'h51, 8'ha2, 8'h86, 8'h52, 8'h4a, 8'h43, 8'h14,
      8'h75, 8'hff, 8'hf5, 8'hcd, 8'h1b, 8'h0d, 8'h35, 8'h24,
      8'h9c, 8'he1, 8'h60, 8'h73, 8'h3e, 8'h39, 8'h53, 8'h16,
      8'h50, 8'h6b, 8'hc9, 8'h46, 8'h57, 8'h5c, 8'h69, 8'h79,
      8'h82, 8'hf1, 8'h27, 8'h38, 8'h34, 8'hf6, 8'h00, 8'ha9
   };

   // Remainder of a byte by a small divisor, by restoring subtraction of
   // the divisor scaled by 16, 8, 4, 2 and 1.
   function automatic logic [5:0] mod_small(input logic [7:0] x, input logic [5:0] d);
      logic [10:0] rem;
      logic [10:0] m;
      rem = {3'd0, x};
      for (int k = 4; k >= 0; k--) begin
         m = {5'd0, d} << k;
         if (rem >= m) begin
            rem = rem - m;
         end
      end
      return rem[5:0];
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
      logic [63:0] t;
      t = {v, v} << r;
      return t[63:32];
   endfunction

   function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
      logic [127:0] t;
      t = {v, v} << r;
      return t[127:64];
   endfunction

endpackage

/* hw/rtl/cpsc_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_req_if: request channel
// Valid/ready channel carrying the request kind and the data byte.
// ----------------------------------------------------------------------------
interface cpsc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

/* hw/rtl/cpsc_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_rsp_if: response channel
// Valid/ready channel carrying the processed data byte.
// ----------------------------------------------------------------------------
interface cpsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

/* hw/rtl/cpsc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_mul: shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module cpsc_mul
   import cpsc_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

/* hw/rtl/combined_prng_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_prng_stream_cipher: byte stream cipher from four generators
// A sequencer drives one shared 32 x 32 multiplier through the generator
// update, the key mix and the substitution of each data byte.
// ----------------------------------------------------------------------------
//  channel   | direction | transaction
//  req_chan  | in        | req_type (restart or data), data_in byte
//  rsp_chan  | out       | data_out byte, one for each data request
//  csr_*     | in        | key register write: csr_we, csr_index, csr_wdata
//
//  A data request runs the sequencer from the generator step to the
//  substitution step: the five multiplies go one after another through the
//  shared multiplier. The next request is accepted only once it is idle again.
//  A restart keeps the input busy for its diffusion rounds, one round per cycle,
//  and gives no response.
//  Reset clears the keys, the generator state and the sequencer.
//  A response that is still waiting holds the sequencer in the substitution step.
// ----------------------------------------------------------------------------
module combined_prng_stream_cipher
   import cpsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cpsc_req_if.sink    req_chan,
   cpsc_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   state_type   state_ff, state_in;
   logic [31:0] key_lcg_ff, key_lfsr_ff, key_nlfs_ff;
   logic [63:0] key_xs_ff;
   logic [31:0] lcg_ff, lcg_in, lfsr_ff, lfsr_in, nlfs_ff, nlfs_in;
   logic [63:0] xs_ff, xs_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rkey_ff, rkey_in;
   logic [7:0]  data_ff, data_in_nx;
   logic [2:0]  round_ff, round_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        req_fire;

   logic [31:0] d_lcg, d_lfsr, d_nlfs;
   logic [5:0]  rot_a, rot_b, rot_c;
   logic [63:0] x1, x2, x3;
   logic [31:0] pm_sum, pm_red;
   logic [63:0] mixed;
   logic [5:0]  rot_r;
   logic [7:0]  sb_acc;

   cpsc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.data_out = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lcg_ff  <= '0;
         key_lfsr_ff <= '0;
         key_nlfs_ff <= '0;
         key_xs_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LCG:  key_lcg_ff  <= csr_wdata[31:0];
            CSR_KEY_LFSR: key_lfsr_ff <= csr_wdata[31:0];
            CSR_KEY_NLFS: key_nlfs_ff <= csr_wdata[31:0];
            CSR_KEY_XS:   key_xs_ff   <= csr_wdata;
            default:      key_xs_ff   <= key_xs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcg_ff       <= '0;
         lfsr_ff      <= '0;
         nlfs_ff      <= '0;
         xs_ff        <= '0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_ff       <= lcg_in;
         lfsr_ff      <= lfsr_in;
         nlfs_ff      <= nlfs_in;
         xs_ff        <= xs_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rkey_ff     <= rkey_in;
      data_ff     <= data_in_nx;
      out_data_ff <= out_data_in;
   end

   // One diffusion round; the third rotate amount comes from the new LCG word.
   always_comb begin
      rot_a  = mod_small(nlfs_ff[7:0], ROT_DIV);
      rot_b  = mod_small(lfsr_ff[7:0], ROT_DIV);
      d_lcg  = lcg_ff ^ rotl32(lfsr_ff, rot_a[4:0]);
      d_lfsr = lfsr_ff ^ rotl32(nlfs_ff, rot_b[4:0]);
      rot_c  = mod_small(d_lcg[7:0], ROT_DIV);
      d_nlfs = nlfs_ff ^ rotl32(lcg_ff, rot_c[4:0]);
   end

   // Xorshift step, Park-Miller fold of the registered product, key mix, rotate amount and S-box sum.
   always_comb begin
      x1     = xs_ff ^ (xs_ff >> 12);
      x2     = x1 ^ (x1 << 25);
      x3     = x2 ^ (x2 >> 27);
      pm_sum = {15'd0, prod[47:31]} + {1'b0, prod[30:0]};
      pm_red = (pm_sum >= PM_MOD) ? (pm_sum - PM_MOD) : pm_sum;
      mixed  = acc_ff ^ (nlfs_ff[0] ? {lcg_ff, lfsr_ff} : prod);
      rot_r  = mod_small(nlfs_ff[7:0], ROTBY_DIV);
      if (rot_r == 6'd0) begin
         rot_r = 6'd1;
      end
      sb_acc = data_ff;
      for (int i = 0; i < 8; i++) begin
         sb_acc = sb_acc ^ SBOX[rkey_ff[8*i +: 8]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      lcg_in       = lcg_ff;
      lfsr_in      = lfsr_ff;
      nlfs_in      = nlfs_ff;
      xs_in        = xs_ff;
      acc_in       = acc_ff;
      rkey_in      = rkey_ff;
      data_in_nx   = data_ff;
      round_in     = round_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_data_in  = out_data_ff;
      mul_a        = lcg_ff;
      mul_b        = PM_MUL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               data_in_nx = req_chan.data_in;
               if (req_kind_type'(req_chan.req_type) == REQ_RESTART) begin
                  lcg_in   = key_lcg_ff ^ SEED_LCG;
                  lfsr_in  = key_lfsr_ff ^ SEED_LFSR;
                  nlfs_in  = key_nlfs_ff ^ SEED_NLFS;
                  xs_in    = key_xs_ff ^ SEED_XS;
                  round_in = '0;
                  state_in = S_DIFF;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_DIFF: begin
            lcg_in   = d_lcg;
            lfsr_in  = d_lfsr;
            nlfs_in  = d_nlfs;
            xs_in    = xs_ff ^ {d_lcg, d_lfsr};
            round_in = round_ff + 3'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_IDLE;
            end
         end
         S_STEP: begin
            // The multiplier takes the old LCG word in this cycle.
            lfsr_in  = (lfsr_ff >> 1) ^ {32{lfsr_ff[0]}};
            nlfs_in  = {1'b0,
                        (nlfs_ff[28] ^ nlfs_ff[0] ^ (nlfs_ff[31:1] == 31'd0)) | nlfs_ff[31],
                        nlfs_ff[30:1]};
            xs_in    = x3;
            state_in = S_LCG;
         end
         S_LCG: begin
            lcg_in   = pm_red;
            mul_a    = xs_ff[31:0];
            mul_b    = XS_MUL_LO;
            state_in = S_M1;
         end
         S_M1: begin
            acc_in   = prod;
            mul_a    = xs_ff[63:32];
            mul_b    = XS_MUL_LO;
            state_in = S_M2;
         end
         S_M2: begin
            acc_in   = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            mul_a    = xs_ff[31:0];
            mul_b    = XS_MUL_HI;
            state_in = S_M3;
         end
         S_M3: begin
            acc_in   = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            mul_a    = lcg_ff;
            mul_b    = lfsr_ff;
            state_in = S_M4;
         end
         S_M4: begin
            rkey_in = mixed;
            if (mod_small(nlfs_ff[7:0], SWAP_DIV) == 6'd0) begin
               lcg_in  = lfsr_ff;
               lfsr_in = lcg_ff;
            end
            if (mod_small(nlfs_ff[7:0], ROT_DIV) == 6'd0) begin
               xs_in = rotl64(xs_ff, rot_r);
            end
            state_in = S_SBOX;
         end
         S_SBOX: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = sb_acc;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIFF |-> round_ff <= LAST_ROUND)
      else $error("diffusion round counter out of range");

   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.req_type == REQ_RESTART) |=> !$rose(out_valid_ff))
      else $error("restart produced a response");

   a_rsp_from_sbox: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_SBOX))
      else $error("response raised outside the substitution step");

   a_data_starts_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.req_type == REQ_DATA) |=> state_ff == S_STEP)
      else $error("data request did not start the generator step");
endmodule
